>>> rtl/cpa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the complex phase angle core.
// Used by cpa_cordic and complex_phase_angle_core; depends on nothing.
package cpa_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int ANGLE_WIDTH  = 16;

  localparam int CORDIC_STEPS = 31;
  localparam int PRESCALE     = 30;

  localparam int MAG_WIDTH = SAMPLE_WIDTH;
  localparam int XY_WIDTH  = SAMPLE_WIDTH + PRESCALE + 2;
  localparam int Z_WIDTH   = 32;
  localparam int A_WIDTH   = 34;

  localparam logic signed [A_WIDTH-1:0] QUARTER_TURN = 34'sd1073741824;
  localparam logic signed [A_WIDTH-1:0] HALF_TURN    = 34'sd2147483648;

  localparam logic signed [Z_WIDTH-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331, 32'sd21354465, 32'sd10679838, 32'sd5340245,
    32'sd2670163, 32'sd1335087, 32'sd667544, 32'sd333772,
    32'sd166886, 32'sd83443, 32'sd41722, 32'sd20861,
    32'sd10430, 32'sd5215, 32'sd2608, 32'sd1304,
    32'sd652, 32'sd326, 32'sd163, 32'sd81,
    32'sd41, 32'sd20, 32'sd10, 32'sd5,
    32'sd3, 32'sd1, 32'sd1
  };

  typedef struct packed {
    logic zero_in;
    logic swap;
    logic re_neg;
    logic negate;
    logic y_zero;
  } cpa_flags_t;

endpackage

>>> rtl/cpa_cordic.sv
`timescale 1ns / 1ps
// Vectoring CORDIC pipeline: one rotation per register stage, first octant.
// Depends on cpa_pkg for widths, the arctangent table and the flag struct.
module cpa_cordic (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [cpa_pkg::MAG_WIDTH-1:0] xm_i,
  input  logic [cpa_pkg::MAG_WIDTH-1:0] ym_i,
  input  cpa_pkg::cpa_flags_t           flags_i,
  output logic                          valid_o,
  output logic signed [cpa_pkg::Z_WIDTH-1:0] z_o,
  output cpa_pkg::cpa_flags_t           flags_o
);
  import cpa_pkg::*;

  logic                       valid_q [CORDIC_STEPS];
  logic signed [XY_WIDTH-1:0] x_q     [CORDIC_STEPS];
  logic signed [XY_WIDTH-1:0] y_q     [CORDIC_STEPS];
  logic signed [Z_WIDTH-1:0]  z_q     [CORDIC_STEPS];
  cpa_flags_t                 flags_q [CORDIC_STEPS];

  logic signed [XY_WIDTH-1:0] x_init;
  logic signed [XY_WIDTH-1:0] y_init;

  assign x_init = {2'b00, xm_i, {PRESCALE{1'b0}}};
  assign y_init = {2'b00, ym_i, {PRESCALE{1'b0}}};

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    logic                       valid_in;
    logic signed [XY_WIDTH-1:0] x_in;
    logic signed [XY_WIDTH-1:0] y_in;
    logic signed [Z_WIDTH-1:0]  z_in;
    cpa_flags_t                 flags_in;
    logic signed [XY_WIDTH-1:0] x_d;
    logic signed [XY_WIDTH-1:0] y_d;
    logic signed [Z_WIDTH-1:0]  z_d;

    if (k == 0) begin : g_first
      assign valid_in = valid_i;
      assign x_in     = x_init;
      assign y_in     = y_init;
      assign z_in     = '0;
      assign flags_in = flags_i;
    end else begin : g_next
      assign valid_in = valid_q[k-1];
      assign x_in     = x_q[k-1];
      assign y_in     = y_q[k-1];
      assign z_in     = z_q[k-1];
      assign flags_in = flags_q[k-1];
    end

    always_comb begin
      if (!y_in[XY_WIDTH-1]) begin
        x_d = x_in + (y_in >>> k);
        y_d = y_in - (x_in >>> k);
        z_d = z_in + ATAN_TAB[k];
      end else begin
        x_d = x_in - (y_in >>> k);
        y_d = y_in + (x_in >>> k);
        z_d = z_in - ATAN_TAB[k];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      x_q[k]     <= x_d;
      y_q[k]     <= y_d;
      z_q[k]     <= z_d;
      flags_q[k] <= flags_in;
    end
  end

  assign valid_o = valid_q[CORDIC_STEPS-1];
  assign z_o     = z_q[CORDIC_STEPS-1];
  assign flags_o = flags_q[CORDIC_STEPS-1];

endmodule

>>> rtl/complex_phase_angle_core.sv
`timescale 1ns / 1ps
// Top level of the complex phase angle core: octant folding, CORDIC, unfolding.
// Depends on cpa_pkg and instantiates cpa_cordic.

// The core takes one complex sample per clock cycle and returns its four-quadrant
// phase angle, in which 32768 stands for pi, through one input stage, 31 CORDIC
// rotation stages and two unfolding stages. The pipeline never stalls, so busy
// stays low and every start beat gives one result strobe, in order; the receiver
// must take each result in the cycle it is shown.
module complex_phase_angle_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [cpa_pkg::SAMPLE_WIDTH-1:0] real_part_i,
  input  logic signed [cpa_pkg::SAMPLE_WIDTH-1:0] imag_part_i,
  output logic                                   result_valid_o,
  output logic signed [cpa_pkg::ANGLE_WIDTH-1:0]  phase_o
);
  import cpa_pkg::*;

  localparam int RND_SHIFT = (ANGLE_WIDTH < 32) ? 31 - ANGLE_WIDTH : 0;
  localparam logic signed [A_WIDTH-1:0] ROUND_BIAS =
    (ANGLE_WIDTH < 32) ? (A_WIDTH'(1) <<< RND_SHIFT) : '0;

  logic [MAG_WIDTH-1:0] ar;
  logic [MAG_WIDTH-1:0] ai;
  cpa_flags_t           flags_d;
  logic [MAG_WIDTH-1:0] xm_d;
  logic [MAG_WIDTH-1:0] ym_d;

  logic                 in_valid_q;
  logic [MAG_WIDTH-1:0] xm_q;
  logic [MAG_WIDTH-1:0] ym_q;
  cpa_flags_t           flags_q;

  logic                      cor_valid;
  logic signed [Z_WIDTH-1:0] cor_z;
  cpa_flags_t                cor_flags;

  logic signed [A_WIDTH-1:0] oct;
  logic signed [A_WIDTH-1:0] a1;
  logic signed [A_WIDTH-1:0] a_d;
  logic signed [A_WIDTH-1:0] a_q;
  logic                      u1_valid_q;
  logic                      negate_q;
  logic                      zero_q;

  logic signed [A_WIDTH-1:0]     sum;
  logic signed [ANGLE_WIDTH-1:0] phase_d;
  logic signed [ANGLE_WIDTH-1:0] phase_q;
  logic                          out_valid_q;

  assign busy = 1'b0;

  always_comb begin
    ar = real_part_i[SAMPLE_WIDTH-1] ? MAG_WIDTH'(-real_part_i) : MAG_WIDTH'(real_part_i);
    ai = imag_part_i[SAMPLE_WIDTH-1] ? MAG_WIDTH'(-imag_part_i) : MAG_WIDTH'(imag_part_i);
    flags_d.zero_in = (real_part_i == '0) && (imag_part_i == '0);
    flags_d.swap    = !(ar > ai);
    flags_d.re_neg  = real_part_i[SAMPLE_WIDTH-1];
    flags_d.negate  = imag_part_i[SAMPLE_WIDTH-1] ||
                      ((imag_part_i == '0) && real_part_i[SAMPLE_WIDTH-1]);
    xm_d            = flags_d.swap ? ai : ar;
    ym_d            = flags_d.swap ? ar : ai;
    flags_d.y_zero  = (ym_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      u1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= start;
      u1_valid_q  <= cor_valid;
      out_valid_q <= u1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    xm_q    <= xm_d;
    ym_q    <= ym_d;
    flags_q <= flags_d;
  end

  cpa_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_q),
    .xm_i    (xm_q),
    .ym_i    (ym_q),
    .flags_i (flags_q),
    .valid_o (cor_valid),
    .z_o     (cor_z),
    .flags_o (cor_flags)
  );

  always_comb begin
    oct = cor_flags.y_zero ? '0 : A_WIDTH'(cor_z);
    a1  = cor_flags.swap ? QUARTER_TURN - oct : oct;
    a_d = cor_flags.re_neg ? HALF_TURN - a1 : a1;
  end

  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    negate_q <= cor_flags.negate;
    zero_q   <= cor_flags.zero_in;
  end

  always_comb begin
    sum     = negate_q ? ROUND_BIAS - a_q : a_q + ROUND_BIAS;
    phase_d = zero_q ? '0 : sum[31 -: ANGLE_WIDTH];
  end

  always_ff @(posedge clk_i) begin
    phase_q <= phase_d;
  end

  assign result_valid_o = out_valid_q;
  assign phase_o        = phase_q;

endmodule
